FILE: src/jmsw_pkg.sv
// Shared types, marker codes and result codes for the JPEG marker segment walker.
// Used by jmsw_step, jmsw_queue and jpeg_marker_segment_walker_top; depends on nothing.
`default_nettype none

package jmsw_pkg;

   localparam logic [7:0] MARK_PREFIX = 8'hFF;
   localparam logic [7:0] MARK_SOI    = 8'hD8;
   localparam logic [7:0] MARK_SOS    = 8'hDA;
   localparam logic [7:0] MARK_EOI    = 8'hD9;
   localparam logic [7:0] MARK_STUFF  = 8'h00;
   localparam logic [7:0] MARK_DQT    = 8'hDB;
   localparam logic [7:0] MARK_DHT    = 8'hC4;
   localparam logic [7:0] MARK_COM    = 8'hFE;
   localparam logic [7:0] MARK_SOF0   = 8'hC0;
   localparam logic [7:0] MARK_SOF2   = 8'hC2;
   localparam logic [7:0] MARK_APP0   = 8'hE0;
   localparam logic [7:0] MARK_APP15  = 8'hEF;

   localparam logic [1:0] KIND_SEGMENT = 2'd0;
   localparam logic [1:0] KIND_EOI     = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] CLS_APP = 3'd0;
   localparam logic [2:0] CLS_DQT = 3'd1;
   localparam logic [2:0] CLS_SOF = 3'd2;
   localparam logic [2:0] CLS_DHT = 3'd3;
   localparam logic [2:0] CLS_SOS = 3'd4;
   localparam logic [2:0] CLS_COM = 3'd5;
   localparam logic [2:0] CLS_EOI = 3'd6;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_START = 3'd1;
   localparam logic [2:0] ERR_NO_PREFIX = 3'd2;
   localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;
   localparam logic [2:0] ERR_SHORT_LEN = 3'd5;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  seg_class;
      logic [7:0]  code;
      logic [31:0] seg_bytes;
      logic [31:0] total;
      logic [2:0]  err;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } step_out_type;

   // Bit 3 is set for a known marker; bits 2:0 give its class.
   function automatic logic [3:0] class_of(input logic [7:0] code);
      logic [3:0] res;
      res = {1'b0, CLS_APP};
      unique case (code) inside
         [MARK_APP0:MARK_APP15]: res = {1'b1, CLS_APP};
         MARK_DQT:               res = {1'b1, CLS_DQT};
         MARK_SOF0, MARK_SOF2:   res = {1'b1, CLS_SOF};
         MARK_DHT:               res = {1'b1, CLS_DHT};
         MARK_SOS:               res = {1'b1, CLS_SOS};
         MARK_COM:               res = {1'b1, CLS_COM};
         MARK_EOI:               res = {1'b1, CLS_EOI};
         default:                res = {1'b0, CLS_APP};
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: src/jmsw_step.sv
// Parser state and the combinational step logic for one registered input byte.
// Depends on jmsw_pkg for marker codes, result codes and the result types.
`default_nettype none

module jmsw_step #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  in_eos,
   output jmsw_pkg::step_out_type     step_out
);

   localparam logic [3:0] PH_START0 = 4'd0;
   localparam logic [3:0] PH_START1 = 4'd1;
   localparam logic [3:0] PH_MARK0  = 4'd2;
   localparam logic [3:0] PH_MARK1  = 4'd3;
   localparam logic [3:0] PH_LENHI  = 4'd4;
   localparam logic [3:0] PH_LENLO  = 4'd5;
   localparam logic [3:0] PH_SKIP   = 4'd6;
   localparam logic [3:0] PH_SCAN   = 4'd7;
   localparam logic [3:0] PH_DONE   = 4'd8;
   localparam logic [3:0] PH_ERROR  = 4'd9;

   logic [3:0]             phase_ff, phase_in;
   logic [7:0]             marker_ff, marker_in;
   logic [7:0]             len_high_ff, len_high_in;
   logic [15:0]            skip_ff, skip_in;
   logic [COUNT_WIDTH-1:0] scan_ff, scan_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic                   saw_ff, saw_in;
   logic [15:0]            seg_len_ff, seg_len_in;

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [COUNT_WIDTH-1:0] b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] clip32(input logic [COUNT_WIDTH-1:0] v);
      logic [63:0] t;
      t = 64'(v);
      return (|t[63:32]) ? 32'hFFFF_FFFF : t[31:0];
   endfunction

   function automatic jmsw_pkg::result_type mk(input logic [1:0] kind,
                                               input logic [2:0] cls,
                                               input logic [7:0] code,
                                               input logic [COUNT_WIDTH-1:0] seg,
                                               input logic [COUNT_WIDTH-1:0] total,
                                               input logic [2:0] err);
      jmsw_pkg::result_type r;
      r.kind      = kind;
      r.seg_class = cls;
      r.code      = code;
      r.seg_bytes = clip32(seg);
      r.total     = clip32(total);
      r.err       = err;
      r.last      = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic                   a_v, b_v, t_v, seg_done;
      jmsw_pkg::result_type   a_r, b_r, t_r, r0, r1;
      logic [3:0]             cm, cs;
      logic [COUNT_WIDTH-1:0] seg;
      logic [1:0]             n;

      phase_in    = phase_ff;
      marker_in   = marker_ff;
      len_high_in = len_high_ff;
      skip_in     = skip_ff;
      scan_in     = scan_ff;
      total_in    = total_ff;
      saw_in      = saw_ff;
      seg_len_in  = seg_len_ff;
      a_v = 1'b0;
      b_v = 1'b0;
      t_v = 1'b0;
      a_r = '0;
      b_r = '0;
      t_r = '0;
      seg_done = 1'b0;
      seg = '0;
      cs = '0;
      cm = jmsw_pkg::class_of(in_byte);

      if (in_valid && phase_ff != PH_DONE && phase_ff != PH_ERROR) begin
         unique case (phase_ff)
            PH_START0: begin
               if (in_byte != jmsw_pkg::MARK_PREFIX) begin
                  a_v = 1'b1;
                  a_r = mk(jmsw_pkg::KIND_ERROR, jmsw_pkg::CLS_APP, in_byte, '0, total_in,
                           jmsw_pkg::ERR_BAD_START);
                  phase_in = PH_ERROR;
               end else begin
                  phase_in = PH_START1;
               end
            end
            PH_START1: begin
               if (in_byte != jmsw_pkg::MARK_SOI) begin
                  a_v = 1'b1;
                  a_r = mk(jmsw_pkg::KIND_ERROR, jmsw_pkg::CLS_APP, in_byte, '0, total_in,
                           jmsw_pkg::ERR_BAD_START);
                  phase_in = PH_ERROR;
               end else begin
                  total_in = sat_add(total_in, COUNT_WIDTH'(2));
                  phase_in = PH_MARK0;
               end
            end
            PH_MARK0: begin
               if (in_byte != jmsw_pkg::MARK_PREFIX) begin
                  a_v = 1'b1;
                  a_r = mk(jmsw_pkg::KIND_ERROR, jmsw_pkg::CLS_APP, in_byte, '0, total_in,
                           jmsw_pkg::ERR_NO_PREFIX);
                  phase_in = PH_ERROR;
               end else begin
                  phase_in = PH_MARK1;
               end
            end
            PH_MARK1: begin
               a_v = 1'b1;
               if (!cm[3]) begin
                  a_r = mk(jmsw_pkg::KIND_ERROR, jmsw_pkg::CLS_APP, in_byte, '0, total_in,
                           jmsw_pkg::ERR_UNKNOWN);
                  phase_in = PH_ERROR;
               end else begin
                  marker_in = in_byte;
                  total_in = sat_add(total_in, COUNT_WIDTH'(2));
                  if (cm[2:0] == jmsw_pkg::CLS_EOI) begin
                     a_r = mk(jmsw_pkg::KIND_EOI, jmsw_pkg::CLS_EOI, in_byte, '0, total_in,
                              jmsw_pkg::ERR_NONE);
                     phase_in = PH_DONE;
                  end else begin
                     a_v = 1'b0;
                     phase_in = PH_LENHI;
                  end
               end
            end
            PH_LENHI: begin
               len_high_in = in_byte;
               phase_in = PH_LENLO;
            end
            PH_LENLO: begin
               seg_len_in = {len_high_ff, in_byte};
               if (seg_len_in < 16'd2) begin
                  a_v = 1'b1;
                  a_r = mk(jmsw_pkg::KIND_ERROR, jmsw_pkg::CLS_APP, marker_in, '0, total_in,
                           jmsw_pkg::ERR_SHORT_LEN);
                  phase_in = PH_ERROR;
               end else begin
                  skip_in = seg_len_in - 16'd2;
                  if (skip_in == 16'd0) begin
                     seg_done = 1'b1;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) begin
                  seg_done = 1'b1;
               end
            end
            PH_SCAN: begin
               if (saw_ff) begin
                  saw_in = 1'b0;
                  if (in_byte == jmsw_pkg::MARK_STUFF) begin
                     scan_in = sat_add(scan_ff, COUNT_WIDTH'(2));
                  end else begin
                     seg = sat_add(COUNT_WIDTH'(seg_len_ff), scan_ff);
                     total_in = sat_add(total_in, seg);
                     a_v = 1'b1;
                     a_r = mk(jmsw_pkg::KIND_SEGMENT, jmsw_pkg::CLS_SOS, jmsw_pkg::MARK_SOS,
                              seg, total_in, jmsw_pkg::ERR_NONE);
                     b_v = 1'b1;
                     if (!cm[3]) begin
                        b_r = mk(jmsw_pkg::KIND_ERROR, jmsw_pkg::CLS_APP, in_byte, '0,
                                 total_in, jmsw_pkg::ERR_UNKNOWN);
                        phase_in = PH_ERROR;
                     end else begin
                        marker_in = in_byte;
                        total_in = sat_add(total_in, COUNT_WIDTH'(2));
                        if (cm[2:0] == jmsw_pkg::CLS_EOI) begin
                           b_r = mk(jmsw_pkg::KIND_EOI, jmsw_pkg::CLS_EOI, in_byte, '0,
                                    total_in, jmsw_pkg::ERR_NONE);
                           phase_in = PH_DONE;
                        end else begin
                           b_v = 1'b0;
                           phase_in = PH_LENHI;
                        end
                     end
                  end
               end else if (in_byte == jmsw_pkg::MARK_PREFIX) begin
                  saw_in = 1'b1;
               end else begin
                  scan_in = sat_add(scan_ff, COUNT_WIDTH'(1));
               end
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase

         if (seg_done) begin
            if (marker_in == jmsw_pkg::MARK_SOS) begin
               scan_in = '0;
               saw_in = 1'b0;
               phase_in = PH_SCAN;
            end else begin
               cs = jmsw_pkg::class_of(marker_in);
               total_in = sat_add(total_in, COUNT_WIDTH'(seg_len_in));
               phase_in = PH_MARK0;
               a_v = 1'b1;
               a_r = mk(jmsw_pkg::KIND_SEGMENT, cs[2:0], marker_in, COUNT_WIDTH'(seg_len_in),
                        total_in, jmsw_pkg::ERR_NONE);
            end
         end

         if (in_eos && phase_in != PH_DONE && phase_in != PH_ERROR) begin
            t_v = 1'b1;
            t_r = mk(jmsw_pkg::KIND_ERROR, jmsw_pkg::CLS_APP, marker_in, '0, total_in,
                     jmsw_pkg::ERR_TRUNCATED);
            phase_in = PH_ERROR;
         end
      end

      n = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, t_v});
      r0 = a_v ? a_r : (b_v ? b_r : t_r);
      r1 = (a_v && b_v) ? b_r : t_r;
      r0.last = (n == 2'd1);
      r1.last = (n == 2'd2);
      step_out.count = n;
      step_out.r0 = r0;
      step_out.r1 = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START0;
         marker_ff   <= '0;
         len_high_ff <= '0;
         skip_ff     <= '0;
         scan_ff     <= '0;
         total_ff    <= '0;
         saw_ff      <= 1'b0;
         seg_len_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         marker_ff   <= marker_in;
         len_high_ff <= len_high_in;
         skip_ff     <= skip_in;
         scan_ff     <= scan_in;
         total_ff    <= total_in;
         saw_ff      <= saw_in;
         seg_len_ff  <= seg_len_in;
      end
   end

   // A finished or failed stream stays in its terminal phase until reset.
   a_terminal_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE || phase_ff == PH_ERROR) |=> $stable(phase_ff))
      else $error("terminal phase left without reset");

   // Bytes after the end of the stream produce no results.
   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE || phase_ff == PH_ERROR) |-> step_out.count == 2'd0)
      else $error("result produced after end of stream");

   // Only the final result of a byte carries the last flag.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      step_out.count == 2'd2 |-> (step_out.r1.last && !step_out.r0.last))
      else $error("last flag misplaced on a pair of results");

endmodule

`default_nettype wire

FILE: src/jmsw_queue.sv
// Result queue: holds up to QUEUE_DEPTH byte steps of one or two results each
// and hands them out one result at a time. Depends on jmsw_pkg.
`default_nettype none

module jmsw_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire jmsw_pkg::step_out_type push_data,
   output logic                       room,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output jmsw_pkg::result_type       out_data
);

   localparam int PtrW = $clog2(jmsw_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(jmsw_pkg::QUEUE_DEPTH + 1);

   jmsw_pkg::step_out_type mem [jmsw_pkg::QUEUE_DEPTH];

   logic [PtrW-1:0] wptr_ff, wptr_in;
   logic [PtrW-1:0] rptr_ff, rptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            sub_ff, sub_in;
   jmsw_pkg::step_out_type head;
   logic            take, pop;

   assign head      = mem[rptr_ff];
   assign out_valid = (cnt_ff != '0);
   assign out_data  = sub_ff ? head.r1 : head.r0;
   assign room      = (cnt_ff <= CntW'(jmsw_pkg::QUEUE_DEPTH - 2));
   assign take      = out_valid && out_ready;
   assign pop       = take && (sub_ff || head.count == 2'd1);

   always_comb begin
      wptr_in = push ? wptr_ff + PtrW'(1) : wptr_ff;
      rptr_in = pop ? rptr_ff + PtrW'(1) : rptr_ff;
      cnt_in  = cnt_ff + CntW'(push) - CntW'(pop);
      sub_in  = sub_ff;
      if (take) begin
         sub_in = !sub_ff && (head.count == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
         sub_ff  <= 1'b0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
         sub_ff  <= sub_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> cnt_ff < CntW'(jmsw_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      push |-> push_data.count != 2'd0)
      else $error("empty step pushed into result queue");

   a_second_exists: assert property (@(posedge clock) disable iff (reset)
      (sub_ff && out_valid) |-> head.count == 2'd2)
      else $error("second result selected from a single-result entry");

endmodule

`default_nettype wire

FILE: src/jpeg_marker_segment_walker_top.sv
// Top level of the JPEG marker segment walker: input register, step logic and result queue.
// Depends on jmsw_pkg, jmsw_step and jmsw_queue.
// Accepted bytes go from the input register through the step logic into the result queue.
// Throughput: one request per cycle unless paused; a byte's two results leave one at a time.
// Request intake pauses when the four-entry result queue cannot take two more steps.
// Reset is synchronous and returns the parser to expect the start marker with all counts zero.
`default_nettype none

module jpeg_marker_segment_walker_top #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] segment_class, [10:3] marker_code, [42:11] segment_bytes,
   // [74:43] total_bytes, [77:75] error_code, [79:78] zero
   output logic [79:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,   // [1:0] event_kind
   output logic             rsp_tlast
);

   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff;
   logic                   eos_ff;
   logic                   room;
   jmsw_pkg::step_out_type step_out;
   jmsw_pkg::result_type   res;

   assign req_tready = room;
   assign valid_in   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_in) begin
         byte_ff <= req_tdata;
         eos_ff  <= req_tlast;
      end
   end

   jmsw_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_ff),
      .in_byte  (byte_ff),
      .in_eos   (eos_ff),
      .step_out (step_out)
   );

   jmsw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (valid_ff && step_out.count != 2'd0),
      .push_data (step_out),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   assign rsp_tdata = {2'b00, res.err, res.total, res.seg_bytes, res.code, res.seg_class};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;

endmodule

`default_nettype wire
